### rtl/cbadc_pkg.sv
// Shared constants, types and state codes for the cell balancer converter block.
package cbadc_pkg;

  localparam int GROUP_SIZE = 64;
  localparam int CNT_W      = $clog2(GROUP_SIZE);
  localparam int SAMPLE_W   = 10;
  localparam int SUM_W      = 16;
  localparam int BIT_W      = $clog2(SUM_W);
  localparam int DIVD_W     = SUM_W + 2;
  localparam int DIVS_W     = 16;
  localparam int STEP_W     = $clog2(DIVD_W);
  localparam int VAL_W      = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_DIVISOR = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_VMAX    = 2'd2;

  localparam logic [DIVS_W-1:0] DIVISOR_RST = 16'd650;
  localparam logic [VAL_W-1:0]  OFFSET_RST  = 8'd160;
  localparam logic [VAL_W-1:0]  VMAX_RST    = 8'd189;

  localparam logic [VAL_W-1:0] DUTY_DN     = 8'd3;
  localparam logic [VAL_W-1:0] DUTY_UP     = 8'd2;
  localparam logic [VAL_W-1:0] DUTY_MAX    = 8'd100;
  localparam logic [VAL_W-1:0] DUTY_PWM_ON = 8'd5;

  localparam logic CH_VOLT = 1'b0;
  localparam logic CH_TEMP = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ADD,
    ST_DIV,
    ST_FIN
  } state_e;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

### rtl/cbadc_sdiv.sv
// Restoring divider, one quotient bit per cycle.
module cbadc_sdiv (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic [cbadc_pkg::DIVD_W-1:0]      dividend_i,
  input  logic [cbadc_pkg::DIVS_W-1:0]      divisor_i,
  output cbadc_pkg::div_stat_t              stat_o,
  output logic [cbadc_pkg::DIVD_W-1:0]      quotient_o
);

  localparam logic [cbadc_pkg::STEP_W-1:0] LAST_STEP =
    cbadc_pkg::STEP_W'(cbadc_pkg::DIVD_W - 1);

  logic                            busy_q, busy_d;
  logic [cbadc_pkg::STEP_W-1:0]    step_q, step_d;
  logic [cbadc_pkg::DIVS_W-1:0]    rem_q, rem_d;
  logic [cbadc_pkg::DIVD_W-1:0]    quo_q, quo_d;
  logic [cbadc_pkg::DIVS_W:0]      rem_sh;
  logic [cbadc_pkg::DIVS_W:0]      rem_sub;
  logic                            ge;

  assign rem_sh  = {rem_q, quo_q[cbadc_pkg::DIVD_W-1]};
  assign rem_sub = rem_sh - {1'b0, divisor_i};
  assign ge      = rem_sh >= {1'b0, divisor_i};

  always_comb begin
    busy_d = busy_q;
    step_d = step_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    if (start_i && !busy_q) begin
      busy_d = 1'b1;
      step_d = '0;
      rem_d  = '0;
      quo_d  = dividend_i;
    end else if (busy_q) begin
      rem_d  = ge ? rem_sub[cbadc_pkg::DIVS_W-1:0] : rem_sh[cbadc_pkg::DIVS_W-1:0];
      quo_d  = {quo_q[cbadc_pkg::DIVD_W-2:0], ge};
      step_d = step_q + 1'b1;
      if (step_q == LAST_STEP) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = busy_q && (step_q == LAST_STEP);
  assign quotient_o  = quo_q;

endmodule

### rtl/cell_balancer_adc_duty_control.sv
// Top level: serial sample summing, group scaling and shunt duty control.
// Each sample word is added bit-serially over all SUM_W bits, then the block is ready again.
// A group-ending voltage word then runs the divider and the finish state;
// a group-ending temperature word goes to the finish state only.
// The result word sits in an output register; the next group can start meanwhile.
// Reset (async, low): sum, count, duty cleared; divisor 650, offset 160, vmax 189.
module cell_balancer_adc_duty_control (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [cbadc_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [cbadc_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic [cbadc_pkg::SAMPLE_W-1:0]       sample_i,
  input  logic                                 channel_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic                                 kind_o,
  output logic [cbadc_pkg::VAL_W-1:0]          value_o,
  output logic                                 clipped_o,
  output logic [cbadc_pkg::VAL_W-1:0]          duty_o,
  output logic                                 pwm_on_o
);

  localparam logic [cbadc_pkg::CNT_W-1:0] LAST_CNT =
    cbadc_pkg::CNT_W'(cbadc_pkg::GROUP_SIZE - 1);
  localparam logic [cbadc_pkg::BIT_W-1:0] LAST_BIT =
    cbadc_pkg::BIT_W'(cbadc_pkg::SUM_W - 1);

  cbadc_pkg::state_e state_q, state_d;

  logic [cbadc_pkg::DIVS_W-1:0]  divisor_q;
  logic [cbadc_pkg::VAL_W-1:0]   offset_q;
  logic [cbadc_pkg::VAL_W-1:0]   vmax_q;

  logic [cbadc_pkg::SUM_W-1:0]   sum_q, sum_d;
  logic [cbadc_pkg::SUM_W-1:0]   samp_q;
  logic                          carry_q;
  logic [cbadc_pkg::BIT_W-1:0]   bit_q;
  logic [cbadc_pkg::CNT_W-1:0]   count_q;
  logic                          group_ch_q;
  logic [cbadc_pkg::VAL_W-1:0]   duty_q;

  logic                          out_valid_q;
  logic                          kind_q;
  logic [cbadc_pkg::VAL_W-1:0]   value_q;
  logic                          clipped_q;
  logic [cbadc_pkg::VAL_W-1:0]   duty_out_q;
  logic                          pwm_on_q;

  logic in_acc, add_en, div_start, fin_load;
  logic add_last, group_end;
  logic sum_bit, carry_d;

  cbadc_pkg::div_stat_t            div_stat;
  logic [cbadc_pkg::DIVD_W-1:0]    quotient;

  logic [cbadc_pkg::DIVD_W-1:0]    q_diff;
  logic [cbadc_pkg::VAL_W-1:0]     volt_val, fin_val, duty_new;
  logic                            volt_clip, fin_clip, dn, up;

  // serial add, LSB first
  assign sum_bit  = sum_q[0] ^ samp_q[0] ^ carry_q;
  assign carry_d  = (sum_q[0] & samp_q[0]) | (carry_q & (sum_q[0] ^ samp_q[0]));
  assign sum_d    = {sum_bit, sum_q[cbadc_pkg::SUM_W-1:1]};
  assign add_last = (bit_q == LAST_BIT);
  assign group_end = (count_q == LAST_CNT);
  assign in_acc   = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      cbadc_pkg::ST_IDLE: if (in_valid_i) state_d = cbadc_pkg::ST_ADD;
      cbadc_pkg::ST_ADD: begin
        if (add_last) begin
          if (!group_end) begin
            state_d = cbadc_pkg::ST_IDLE;
          end else if (group_ch_q == cbadc_pkg::CH_VOLT) begin
            state_d = cbadc_pkg::ST_DIV;
          end else begin
            state_d = cbadc_pkg::ST_FIN;
          end
        end
      end
      cbadc_pkg::ST_DIV: if (div_stat.done) state_d = cbadc_pkg::ST_FIN;
      cbadc_pkg::ST_FIN: if (!out_valid_q || out_ready_i) state_d = cbadc_pkg::ST_IDLE;
      default: state_d = cbadc_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o = 1'b0;
    add_en     = 1'b0;
    div_start  = 1'b0;
    fin_load   = 1'b0;
    unique case (state_q)
      cbadc_pkg::ST_IDLE: in_ready_o = 1'b1;
      cbadc_pkg::ST_ADD: begin
        add_en    = 1'b1;
        div_start = add_last && group_end && (group_ch_q == cbadc_pkg::CH_VOLT);
      end
      cbadc_pkg::ST_DIV: ;
      cbadc_pkg::ST_FIN: fin_load = !out_valid_q || out_ready_i;
      default: ;
    endcase
  end

  cbadc_sdiv u_sdiv (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i ({sum_d, 2'b00}),
    .divisor_i  (divisor_q),
    .stat_o     (div_stat),
    .quotient_o (quotient)
  );

  // saturate quotient minus offset, then step duty
  assign q_diff = quotient - cbadc_pkg::DIVD_W'(offset_q);

  always_comb begin
    if (quotient < cbadc_pkg::DIVD_W'(offset_q)) begin
      volt_val  = '0;
      volt_clip = 1'b1;
    end else if (q_diff > cbadc_pkg::DIVD_W'(8'd255)) begin
      volt_val  = 8'd255;
      volt_clip = 1'b1;
    end else begin
      volt_val  = q_diff[cbadc_pkg::VAL_W-1:0];
      volt_clip = 1'b0;
    end
  end

  assign dn = (volt_val < vmax_q) && (duty_q > cbadc_pkg::DUTY_DN);
  assign up = ({1'b0, volt_val} > ({1'b0, vmax_q} + 9'd1)) && (duty_q < cbadc_pkg::DUTY_MAX);

  always_comb begin
    if (group_ch_q == cbadc_pkg::CH_VOLT) begin
      fin_val  = volt_val;
      fin_clip = volt_clip;
      priority if (dn) begin
        duty_new = duty_q - cbadc_pkg::DUTY_DN;
      end else if (up) begin
        duty_new = duty_q + cbadc_pkg::DUTY_UP;
      end else begin
        duty_new = duty_q;
      end
    end else begin
      fin_val  = sum_q[cbadc_pkg::SUM_W-1 -: cbadc_pkg::VAL_W];
      fin_clip = 1'b0;
      duty_new = duty_q;
    end
  end

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      divisor_q <= cbadc_pkg::DIVISOR_RST;
      offset_q  <= cbadc_pkg::OFFSET_RST;
      vmax_q    <= cbadc_pkg::VMAX_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        cbadc_pkg::CFG_DIVISOR: divisor_q <= cfg_data_i;
        cbadc_pkg::CFG_OFFSET:  offset_q  <= cfg_data_i[cbadc_pkg::VAL_W-1:0];
        cbadc_pkg::CFG_VMAX:    vmax_q    <= cfg_data_i[cbadc_pkg::VAL_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= cbadc_pkg::ST_IDLE;
      sum_q       <= '0;
      carry_q     <= 1'b0;
      bit_q       <= '0;
      count_q     <= '0;
      group_ch_q  <= cbadc_pkg::CH_VOLT;
      duty_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (in_acc) begin
        carry_q <= 1'b0;
        bit_q   <= '0;
        if (count_q == '0) begin
          group_ch_q <= channel_i;
        end
      end
      if (add_en) begin
        sum_q   <= sum_d;
        carry_q <= carry_d;
        bit_q   <= bit_q + 1'b1;
        if (add_last && !group_end) begin
          count_q <= count_q + 1'b1;
        end
      end
      if (out_valid_q && out_ready_i && !fin_load) begin
        out_valid_q <= 1'b0;
      end
      if (fin_load) begin
        out_valid_q <= 1'b1;
        duty_q      <= duty_new;
        sum_q       <= '0;
        count_q     <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      samp_q <= {{(cbadc_pkg::SUM_W - cbadc_pkg::SAMPLE_W){1'b0}}, sample_i};
    end else if (add_en) begin
      samp_q <= {1'b0, samp_q[cbadc_pkg::SUM_W-1:1]};
    end
    if (fin_load) begin
      kind_q     <= group_ch_q;
      value_q    <= fin_val;
      clipped_q  <= fin_clip;
      duty_out_q <= duty_new;
      pwm_on_q   <= duty_new >= cbadc_pkg::DUTY_PWM_ON;
    end
  end

  assign out_valid_o = out_valid_q;
  assign kind_o      = kind_q;
  assign value_o     = value_q;
  assign clipped_o   = clipped_q;
  assign duty_o      = duty_out_q;
  assign pwm_on_o    = pwm_on_q;

  a_div_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == cbadc_pkg::ST_DIV |-> div_stat.busy)
    else $error("divider idle while waiting on quotient");

  a_fin_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == cbadc_pkg::ST_DIV || state_q == cbadc_pkg::ST_FIN) |-> count_q == LAST_CNT)
    else $error("group finish without full count");

  a_duty_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    duty_q < 8'd102)
    else $error("duty out of range");

  a_add_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> state_q == cbadc_pkg::ST_ADD && bit_q == '0)
    else $error("accepted word did not start serial add");

endmodule
